[design/ccgs_pkg.sv]
// Package with the types, sizes and state codes of the circle column grouping sorter.
package ccgs_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 2 * IW + 16;
  localparam logic [15:0] GAP_RESET = 16'd480;

  typedef struct packed {
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    logic [15:0] radius;
    logic        set_end;
  } item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_radius;
    logic [5:0]  group_index;
    logic        group_end;
    logic        set_last;
    logic        overflow_seen;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_A,
    ST_COMMIT_A,
    ST_INIT_B,
    ST_SCAN_B,
    ST_COMMIT_B,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic load;
    logic init_a;
    logic init_b;
    logic scan;
    logic phase_b;
    logic commit_a;
    logic commit_b;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic rank_end;
  } status_t;

endpackage

[design/ccgs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module ccgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/ccgs_ctrl.sv]
// Controller state machine that sequences loading, the x ranking pass and the y emission pass.
module ccgs_ctrl
  import ccgs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    set_end_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (set_end_i) begin
            cmd_o.init_a = 1'b1;
            state_d      = ST_SCAN_A;
          end
        end
      end
      ST_SCAN_A: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_COMMIT_A;
        end
      end
      ST_COMMIT_A: begin
        cmd_o.commit_a = 1'b1;
        state_d        = status_i.rank_end ? ST_INIT_B : ST_SCAN_A;
      end
      ST_INIT_B: begin
        cmd_o.init_b  = 1'b1;
        cmd_o.phase_b = 1'b1;
        state_d       = ST_SCAN_B;
      end
      ST_SCAN_B: begin
        cmd_o.scan    = 1'b1;
        cmd_o.phase_b = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_COMMIT_B;
        end
      end
      ST_COMMIT_B: begin
        cmd_o.commit_b = 1'b1;
        cmd_o.phase_b  = 1'b1;
        state_d        = status_i.rank_end ? ST_FINAL : ST_SCAN_B;
      end
      ST_FINAL: begin
        cmd_o.final_emit = 1'b1;
        state_d          = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign busy_o = (state_q != ST_LOAD);

endmodule

[design/ccgs_datapath.sv]
// Datapath: circle store, rank and group tags, scanning comparator and result register.
module ccgs_datapath
  import ccgs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  item_t       item_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output status_t     status_o,
  output logic        result_valid_o,
  output result_t     result_o
);

  logic [CW-1:0]   cnt_q;
  logic            ovf_q;
  logic [15:0]     thr_q;
  logic [CW-1:0]   j_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  logic            first_q;
  logic [IW-1:0]   rank_q;
  logic [IW-1:0]   g_q;
  logic [KW-1:0]   prev_key_q;
  logic [15:0]     prev_x_q;
  logic            best_vld_q;
  logic [KW-1:0]   best_key_q;
  logic [IW-1:0]   best_idx_q;
  logic [47:0]     best_circ_q;
  logic [IW-1:0]   best_g_q;
  logic            pend_vld_q;
  logic [47:0]     pend_circ_q;
  logic [IW-1:0]   pend_g_q;
  logic            res_vld_q;
  result_t         res_q;

  logic            store_ok;
  logic            issue;
  logic [47:0]     circ_rd;
  logic [2*IW-1:0] tag_rd;
  logic            tag_we;
  logic [2*IW-1:0] tag_wdata;
  logic [KW-1:0]   cand_key;
  logic            cand_take;
  logic [16:0]     gap;
  logic [IW-1:0]   g_new;

  assign store_ok = (cnt_q < CW'(CAPACITY));
  assign issue    = cmd_i.scan && (j_q < cnt_q);

  // Circle store, written in arrival order.
  ccgs_ram #(.WIDTH(48), .DEPTH(CAPACITY)) u_circ_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && store_ok),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({item_i.centre_x, item_i.centre_y, item_i.radius}),
    .raddr_i (j_q[IW-1:0]),
    .rdata_o (circ_rd)
  );

  // Group and x rank of each stored circle, by arrival slot.
  ccgs_ram #(.WIDTH(2 * IW), .DEPTH(CAPACITY)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (best_idx_q),
    .wdata_i (tag_wdata),
    .raddr_i (j_q[IW-1:0]),
    .rdata_o (tag_rd)
  );

  // Sort key of the word read this cycle: x then slot, or group, y, x rank.
  always_comb begin
    if (cmd_i.phase_b) begin
      cand_key = {tag_rd[2*IW-1:IW], circ_rd[31:16], tag_rd[IW-1:0]};
    end else begin
      cand_key = {{IW{1'b0}}, circ_rd[47:32], rd_idx_q};
    end
    cand_take = rd_vld_q && (first_q || (cand_key > prev_key_q)) &&
                (!best_vld_q || (cand_key < best_key_q));
  end

  // Group number of the circle that takes the next x rank.
  always_comb begin
    gap = {1'b0, best_circ_q[47:32]} - {1'b0, prev_x_q};
    if (first_q) begin
      g_new = '0;
    end else if (gap > {1'b0, thr_q}) begin
      g_new = g_q + IW'(1);
    end else begin
      g_new = g_q;
    end
  end

  assign tag_we    = cmd_i.commit_a;
  assign tag_wdata = {g_new, rank_q};

  assign status_o.scan_end = rd_vld_q && ((CW'(rd_idx_q) + CW'(1)) == cnt_q);
  assign status_o.rank_end = ((CW'(rank_q) + CW'(1)) == cnt_q);

  // Control state: fill count, overflow, threshold, scan and rank counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      thr_q      <= GAP_RESET;
      j_q        <= '0;
      rd_vld_q   <= 1'b0;
      first_q    <= 1'b1;
      rank_q     <= '0;
      g_q        <= '0;
      best_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (store_ok) begin
          cnt_q <= cnt_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      rd_vld_q <= issue;
      if (issue) begin
        j_q <= j_q + CW'(1);
      end
      if (cand_take) begin
        best_vld_q <= 1'b1;
      end
      res_vld_q <= 1'b0;
      if (cmd_i.init_a || cmd_i.init_b) begin
        first_q    <= 1'b1;
        rank_q     <= '0;
        j_q        <= '0;
        best_vld_q <= 1'b0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.commit_a || cmd_i.commit_b) begin
        first_q    <= 1'b0;
        rank_q     <= rank_q + IW'(1);
        j_q        <= '0;
        best_vld_q <= 1'b0;
      end
      if (cmd_i.commit_a) begin
        g_q <= g_new;
      end
      if (cmd_i.commit_b) begin
        pend_vld_q <= 1'b1;
        res_vld_q  <= pend_vld_q;
      end
      if (cmd_i.final_emit) begin
        res_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
      end
    end
  end

  // Payload registers: read slot, best candidate, pending word and result.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= j_q[IW-1:0];
    if (cand_take) begin
      best_key_q  <= cand_key;
      best_idx_q  <= rd_idx_q;
      best_circ_q <= circ_rd;
      best_g_q    <= tag_rd[2*IW-1:IW];
    end
    if (cmd_i.commit_a || cmd_i.commit_b) begin
      prev_key_q <= best_key_q;
      prev_x_q   <= best_circ_q[47:32];
    end
    if (cmd_i.commit_b) begin
      pend_circ_q <= best_circ_q;
      pend_g_q    <= best_g_q;
    end
    if (cmd_i.commit_b || cmd_i.final_emit) begin
      res_q.out_x         <= pend_circ_q[47:32];
      res_q.out_y         <= pend_circ_q[31:16];
      res_q.out_radius    <= pend_circ_q[15:0];
      res_q.group_index   <= 6'(pend_g_q);
      res_q.group_end     <= cmd_i.final_emit || (pend_g_q != best_g_q);
      res_q.set_last      <= cmd_i.final_emit;
      res_q.overflow_seen <= ovf_q;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("circle count above capacity");

  // A result word follows only an emission commit or the final emission.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> ($past(cmd_i.commit_b) || $past(cmd_i.final_emit)))
    else $error("result word without emission command");

  // After the last word of a set the store is empty again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.set_last) |-> (cnt_q == '0 && !ovf_q))
    else $error("set not cleared after last word");

  // An emission commit only happens after a candidate was taken in its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_b |-> best_vld_q)
    else $error("emission commit without a candidate");

endmodule

[design/circle_column_grouping_sorter_unit.sv]
// Top level of the circle column grouping sorter: controller plus datapath.
//
// Circles are taken one per cycle while busy is low; the word with set_end starts sorting and
// busy stays high until the last result is out. With n stored circles (n up to CAPACITY), an
// x ranking pass and a y emission pass each make n scans over the circle store, one store read
// per cycle. Results appear during the second pass, each for one cycle on result_valid_o; the
// receiver cannot stall them. The threshold register takes a write in any cycle and is meant to
// be written only while busy is low.
module circle_column_grouping_sorter_unit
  import ccgs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencing.
  ccgs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .set_end_i (item_i.set_end),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // Storage and compare.
  ccgs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
